FILE: src/i8alu_pkg.sv
package i8alu_pkg;

  // Operation codes carried in the kind field; codes 6 and 7 give a zero result.
  typedef enum logic [2:0] {
    KIND_NEG = 3'd0,
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_MUL = 3'd3,
    KIND_DIV = 3'd4,
    KIND_FMA = 3'd5
  } kind_t;

  // Raw operation as captured from the input channel.
  typedef struct packed {
    logic [2:0] kind;
    logic       sgn;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } op_t;

  // Working record that travels down the divider and result stages.
  typedef struct packed {
    logic [2:0] kind;
    logic       neg;
    logic [7:0] dvd;
    logic [7:0] dvs;
    logic [7:0] c;
    logic [8:0] rem;
    logic [7:0] quot;
    logic [7:0] res;
  } wk_t;

  // Magnitude of a two's complement byte; the most negative value stays 0x80 (128).
  function automatic logic [7:0] mag8(input logic [7:0] x);
    logic [7:0] m;
    m = x[7] ? (8'd0 - x) : x;
    return m;
  endfunction

  // One restoring step: shift in the next dividend bit and subtract when it fits.
  // Returns the new nine-bit remainder above the quotient bit.
  function automatic logic [9:0] div_step(input logic [8:0] rem,
                                          input logic       dbit,
                                          input logic [7:0] dvs);
    logic [8:0] sh;
    logic [9:0] r;
    sh = {rem[7:0], dbit};
    if (sh >= {1'b0, dvs}) begin
      r = {sh - {1'b0, dvs}, 1'b1};
    end else begin
      r = {sh, 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: src/i8alu_if.sv
interface i8alu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       is_signed;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic [7:0] operand_c;

  modport source (output valid, kind, is_signed, operand_a, operand_b, operand_c,
                  input ready);
  modport sink (input valid, kind, is_signed, operand_a, operand_b, operand_c,
                output ready);
endinterface

interface i8alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, result_byte, input ready);
  modport sink (input valid, result_byte, output ready);
endinterface

FILE: src/int8_alu.sv
// int8_alu: eight-bit integer ALU with a pipelined restoring divider.
// Throughput is one beat per cycle while the result side does not stall;
// the four divider stages retire two quotient bits each.
// A stall on the result side holds the whole pipeline in place, losing nothing.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module int8_alu
  import i8alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i8alu_in_if.sink    in_ch,
  i8alu_out_if.source out_ch
);

  // Stage 0 holds the raw operation. Stages 1 to 4 hold the working record;
  // each of them runs two restoring steps, and stage 4 also drives the output.
  op_t        op0_r;
  wk_t        st1_r, st2_r, st3_r, st4_r;
  wk_t        st1_nxt, st2_nxt, st3_nxt, st4_nxt;
  logic [4:0] vld_r;
  logic       adv;

  // The pipeline moves as one piece whenever the output register is free or
  // being drained this cycle. Bubbles travel along with their valid bit low.
  assign adv          = !vld_r[4] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[4];
  assign out_ch.result_byte = st4_r.res;

  // Stage 1: operand magnitudes and the quotient sign for signed division,
  // the first two restoring steps, and the results of the non-divide kinds.
  // The product feeds both multiply and fused multiply-add; the addend is
  // applied one stage later so that the multiplier has a register behind it.
  always_comb begin
    logic [9:0]  t;
    logic [15:0] prod;
    st1_nxt      = '0;
    st1_nxt.kind = op0_r.kind;
    st1_nxt.c    = op0_r.c;
    st1_nxt.neg  = op0_r.sgn & (op0_r.a[7] ^ op0_r.b[7]);
    st1_nxt.dvd  = op0_r.sgn ? mag8(op0_r.a) : op0_r.a;
    st1_nxt.dvs  = op0_r.sgn ? mag8(op0_r.b) : op0_r.b;
    t = div_step(9'd0, st1_nxt.dvd[7], st1_nxt.dvs);
    st1_nxt.quot[7] = t[0];
    t = div_step(t[9:1], st1_nxt.dvd[6], st1_nxt.dvs);
    st1_nxt.quot[6] = t[0];
    st1_nxt.rem = t[9:1];
    prod = op0_r.a * op0_r.b;
    unique case (op0_r.kind)
      KIND_NEG: st1_nxt.res = 8'd0 - op0_r.a;
      KIND_ADD: st1_nxt.res = op0_r.a + op0_r.b;
      KIND_SUB: st1_nxt.res = op0_r.a - op0_r.b;
      KIND_MUL: st1_nxt.res = prod[7:0];
      KIND_FMA: st1_nxt.res = prod[7:0];
      default:  st1_nxt.res = 8'd0;
    endcase
  end

  // Stage 2: restoring steps for quotient bits 5 and 4, and the addend of
  // fused multiply-add.
  always_comb begin
    logic [9:0] t;
    st2_nxt = st1_r;
    t = div_step(st1_r.rem, st1_r.dvd[5], st1_r.dvs);
    st2_nxt.quot[5] = t[0];
    t = div_step(t[9:1], st1_r.dvd[4], st1_r.dvs);
    st2_nxt.quot[4] = t[0];
    st2_nxt.rem = t[9:1];
    if (st1_r.kind == KIND_FMA) begin
      st2_nxt.res = st1_r.res + st1_r.c;
    end
  end

  // Stage 3: restoring steps for quotient bits 3 and 2.
  always_comb begin
    logic [9:0] t;
    st3_nxt = st2_r;
    t = div_step(st2_r.rem, st2_r.dvd[3], st2_r.dvs);
    st3_nxt.quot[3] = t[0];
    t = div_step(t[9:1], st2_r.dvd[2], st2_r.dvs);
    st3_nxt.quot[2] = t[0];
    st3_nxt.rem = t[9:1];
  end

  // Stage 4: the last two restoring steps, then the sign rule. A zero divisor
  // needs no special handling: every step fits, so the raw quotient is 255.
  always_comb begin
    logic [9:0] t;
    st4_nxt = st3_r;
    t = div_step(st3_r.rem, st3_r.dvd[1], st3_r.dvs);
    st4_nxt.quot[1] = t[0];
    t = div_step(t[9:1], st3_r.dvd[0], st3_r.dvs);
    st4_nxt.quot[0] = t[0];
    st4_nxt.rem = t[9:1];
    if (st3_r.kind == KIND_DIV) begin
      st4_nxt.res = st3_r.neg ? (8'd0 - st4_nxt.quot) : st4_nxt.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r.kind <= in_ch.kind;
      op0_r.sgn  <= in_ch.is_signed;
      op0_r.a    <= in_ch.operand_a;
      op0_r.b    <= in_ch.operand_b;
      op0_r.c    <= in_ch.operand_c;
      st1_r      <= st1_nxt;
      st2_r      <= st2_nxt;
      st3_r      <= st3_nxt;
      st4_r      <= st4_nxt;
    end
  end

endmodule

FILE: bench/int8_alu_checker.sv
// Watches both channels of the ALU, predicts each result byte from the accepted
// input beat and compares it with the result beats in order.
module int8_alu_checker
  import i8alu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic       in_is_signed,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  input  logic [7:0] in_operand_c,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_result_byte,
  output int         errors,
  output int         pending,
  output int         checked
);

  logic [7:0] expected_bytes[$];

  // Nine-bit magnitude, so that the most negative byte becomes 128.
  function automatic logic [8:0] byte_magnitude(input logic [7:0] x);
    return x[7] ? (9'h100 - {1'b0, x}) : {1'b0, x};
  endfunction

  // Restoring division with a nine-bit partial remainder.
  function automatic logic [7:0] restoring_quotient(input logic [8:0] dividend,
                                                    input logic [8:0] divisor);
    logic [8:0] rem;
    logic [7:0] quot;
    rem  = '0;
    quot = '0;
    for (int i = 7; i >= 0; i--) begin
      rem = {rem[7:0], dividend[i]};
      if (rem >= divisor) begin
        rem     = rem - divisor;
        quot[i] = 1'b1;
      end
    end
    return quot;
  endfunction

  function automatic logic [7:0] alu_result(input logic [2:0] kind, input logic sgn,
                                            input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [7:0]  q;
    logic [15:0] prod;
    prod = a * b;
    case (kind)
      KIND_NEG: return 8'd0 - a;
      KIND_ADD: return a + b;
      KIND_SUB: return a - b;
      KIND_MUL: return prod[7:0];
      KIND_DIV: begin
        if (sgn) begin
          q = restoring_quotient(byte_magnitude(a), byte_magnitude(b));
          return (a[7] ^ b[7]) ? (8'd0 - q) : q;
        end
        return restoring_quotient({1'b0, a}, {1'b0, b});
      end
      KIND_FMA: return prod[7:0] + c;
      default: return 8'd0;
    endcase
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_bytes.push_back(alu_result(in_kind, in_is_signed, in_operand_a,
                                            in_operand_b, in_operand_c));
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %02h",
                   $time, out_result_byte);
          errors++;
        end else begin
          if (out_result_byte !== expected_bytes[0]) begin
            $display("%0t: result_byte mismatch, expected %02h, actual %02h",
                     $time, expected_bytes[0], out_result_byte);
            errors++;
          end
          void'(expected_bytes.pop_front());
          checked++;
        end
      end
      pending = expected_bytes.size();
    end
  end

endmodule

FILE: bench/int8_alu_tb.sv
// Top level of the ALU bench. It makes the clock and reset, drives operation
// beats into the block, plays the result receiver and gives the verdict. All
// prediction and comparison happen in the checker instantiated beside the block.
module int8_alu_tb
  import i8alu_pkg::*;
();

  // The two codes above the defined operations; the block answers them with zero.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // The run is short; this bound is many times the slowest correct run.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int IDLE_PERCENT  = 12;
  // The drain after the last result covers the pipeline and some.
  localparam int DRAIN_CYCLES  = 20;

  logic clk;
  logic rst_n;
  logic quiet;
  int   cycle_count;
  int   errors;
  int   pending;
  int   checked;
  int   sent_per_kind[8];

  i8alu_in_if  in_ch();
  i8alu_out_if out_ch();

  int8_alu DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int8_alu_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_kind         (in_ch.kind),
    .in_is_signed    (in_ch.is_signed),
    .in_operand_a    (in_ch.operand_a),
    .in_operand_b    (in_ch.operand_b),
    .in_operand_c    (in_ch.operand_c),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result_byte (out_ch.result_byte),
    .errors          (errors),
    .pending         (pending),
    .checked         (checked)
  );

  // Free-running clock with a period of ten time units.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input of the block starts at a known value before the first edge.
  initial begin
    rst_n              = 1'b0;
    quiet              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.is_signed    = 1'b0;
    in_ch.operand_a    = '0;
    in_ch.operand_b    = '0;
    in_ch.operand_c    = '0;
    out_ch.ready       = 1'b0;
    cycle_count        = 0;
  end

  // The receiver stalls at random with the idle percentage as its chance, except
  // while the quiet stretch is on. Ready changes only on the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drives one operation beat and returns on the falling edge after it was
  // accepted. Each cycle before the beat idles with the idle percentage, so
  // valid may drop low first. When there is no gap, valid simply stays high
  // into the next beat.
  task automatic send_op(input logic [2:0] kind, input logic sgn, input logic [7:0] a,
                         input logic [7:0] b, input logic [7:0] c);
    int gap;
    gap = 0;
    while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
      gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.is_signed <= sgn;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.operand_c <= c;
    do @(posedge clk); while (!in_ch.ready);
    sent_per_kind[kind]++;
    @(negedge clk);
  endtask

  // Holds the sender idle until the checker has seen every expected result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Operand bytes lean toward the values where arithmetic edges live.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_op();
    logic [2:0] kind;
    logic [7:0] b;
    if ($urandom_range(99) < 4) begin
      kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end else begin
      kind = 3'($urandom_range(5));
    end
    b = pick_byte();
    // Division gets extra divide-by-zero cases on top of what pick_byte gives.
    if (kind == KIND_DIV && $urandom_range(9) == 0) begin
      b = 8'h00;
    end
    send_op(kind, 1'($urandom_range(1)), pick_byte(), b, pick_byte());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: wrap-around edges of the non-divide operations first.
    send_op(KIND_NEG, 1'b0, 8'h00, 8'hAA, 8'h55);
    send_op(KIND_NEG, 1'b1, 8'h80, 8'hFF, 8'h00);
    send_op(KIND_ADD, 1'b0, 8'hFF, 8'h01, 8'hFF);
    send_op(KIND_SUB, 1'b0, 8'h00, 8'h01, 8'h00);
    send_op(KIND_MUL, 1'b1, 8'hFF, 8'hFF, 8'h00);
    send_op(KIND_FMA, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_op(KIND_FMA, 1'b1, 8'h10, 8'h10, 8'h01);
    // Plain unsigned division and divisors above half range, which need the
    // full nine-bit partial remainder.
    send_op(KIND_DIV, 1'b0, 8'hFF, 8'h01, 8'h00);
    send_op(KIND_DIV, 1'b0, 8'hC8, 8'hC9, 8'h00);
    send_op(KIND_DIV, 1'b0, 8'hFF, 8'h80, 8'h00);
    send_op(KIND_DIV, 1'b0, 8'hFF, 8'hFF, 8'h00);
    // Division by zero, unsigned and with either dividend sign.
    send_op(KIND_DIV, 1'b0, 8'h37, 8'h00, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h80, 8'h00, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h05, 8'h00, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h00, 8'h00, 8'h00);
    // The most negative dividend, and mixed signs.
    send_op(KIND_DIV, 1'b1, 8'h80, 8'hFF, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h80, 8'h01, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h80, 8'h80, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h07, 8'hFE, 8'h00);
    send_op(KIND_DIV, 1'b1, 8'h7F, 8'h80, 8'h00);
    // The two undefined codes.
    send_op(KIND_SPARE_LO, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_op(KIND_SPARE_HI, 1'b1, 8'h12, 8'h34, 8'h56);

    // Let the pipeline run dry before the random part starts.
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch in the middle runs with neither side idling.
      quiet = (n >= 250 && n < 370);
      // Once more the sender waits for every outstanding result.
      if (n == 450) begin
        drain_results();
      end
      send_random_op();
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait for the last results, then wait out the drain so that a stray
    // extra beat would still be caught.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d operations: neg %0d, add %0d, sub %0d, mul %0d,",
             sent_per_kind.sum(), sent_per_kind[KIND_NEG], sent_per_kind[KIND_ADD],
             sent_per_kind[KIND_SUB], sent_per_kind[KIND_MUL]);
    $display("  div %0d, fma %0d, undefined %0d; checked %0d result beats, %0d mismatches.",
             sent_per_kind[KIND_DIV], sent_per_kind[KIND_FMA],
             sent_per_kind[KIND_SPARE_LO] + sent_per_kind[KIND_SPARE_HI],
             checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
